// ----- hw/rtl/grid_occupancy_id_table_core_macros.svh -----
// ----------------------------------------------------------------------------
// Grid occupancy id table: assertion macros
// Shorthand for concurrent checks on clk, with or without the reset guard.
// ----------------------------------------------------------------------------
`ifndef GRID_OCCUPANCY_ID_TABLE_CORE_MACROS_SVH
`define GRID_OCCUPANCY_ID_TABLE_CORE_MACROS_SVH

// Check that is switched off while rst_n is low.
`define GOIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that also applies during reset.
`define GOIT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/goit_pkg.sv -----
// ----------------------------------------------------------------------------
// Grid occupancy id table: package
// Shared codes, field widths, state encoding and the config and result types.
// ----------------------------------------------------------------------------
package goit_pkg;

  localparam int ID_W    = 8;
  localparam int COORD_W = 4;
  localparam int CFG_W   = 5;
  localparam int ENTRY_W = 9;
  localparam int PIECES  = 256;
  localparam int OP_W    = 3;
  localparam int ST_W    = 3;
  localparam int REG_W   = 1;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_MOVE   = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_BOUNDS    = 3'd1;
  localparam logic [ST_W-1:0] ST_NOPIECE   = 3'd2;
  localparam logic [ST_W-1:0] ST_OCCUPIED  = 3'd3;
  localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd4;

  localparam logic [REG_W-1:0] REG_BOARD_WIDTH  = 1'd0;
  localparam logic [REG_W-1:0] REG_BOARD_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] BOARD_RESET = 5'd16;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_WR2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [CFG_W-1:0] board_width;
    logic [CFG_W-1:0] board_height;
  } cfg_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [ID_W-1:0]    result_id;
    logic               id_valid;
    logic [COORD_W-1:0] found_x;
    logic [COORD_W-1:0] found_y;
  } result_t;

endpackage

// ----- hw/rtl/goit_ram.sv -----
// ----------------------------------------------------------------------------
// Grid occupancy id table: table memory
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module goit_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/goit_ctrl.sv -----
// ----------------------------------------------------------------------------
// Grid occupancy id table: sequencer
// Clears both tables after reset, then for each request reads and checks the
// cell and piece tables, writes them back where the request changes them, and holds the result for output.
// ----------------------------------------------------------------------------
`include "grid_occupancy_id_table_core_macros.svh"

module goit_ctrl #(
  parameter int MAX_COLS = 16,
  parameter int MAX_ROWS = 16,
  parameter int CIDX_W   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  goit_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [goit_pkg::OP_W-1:0]     in_opcode,
  input  logic [goit_pkg::ID_W-1:0]     in_piece_id,
  input  logic [goit_pkg::COORD_W-1:0]  in_cell_x,
  input  logic [goit_pkg::COORD_W-1:0]  in_cell_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output goit_pkg::result_t             out_res,
  output logic                          cell_we,
  output logic [CIDX_W-1:0]             cell_waddr,
  output logic [goit_pkg::ENTRY_W-1:0]  cell_wdata,
  output logic [CIDX_W-1:0]             cell_raddr,
  input  logic [goit_pkg::ENTRY_W-1:0]  cell_rdata,
  output logic                          piece_we,
  output logic [goit_pkg::ID_W-1:0]     piece_waddr,
  output logic [goit_pkg::ENTRY_W-1:0]  piece_wdata,
  output logic [goit_pkg::ID_W-1:0]     piece_raddr,
  input  logic [goit_pkg::ENTRY_W-1:0]  piece_rdata
);

  localparam int NUM_CELLS = MAX_COLS * MAX_ROWS;
  localparam int CLR_DEPTH = (NUM_CELLS > goit_pkg::PIECES) ? NUM_CELLS : goit_pkg::PIECES;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam logic [6:0] MAXC_L = 7'(MAX_COLS);
  localparam logic [6:0] MAXR_L = 7'(MAX_ROWS);

  function automatic logic [CIDX_W-1:0] cell_index(input logic [3:0] cx,
                                                    input logic [3:0] cy);
    logic [11:0] full;
    full = 12'(cx) * 12'(MAX_ROWS) + 12'(cy);
    return full[CIDX_W-1:0];
  endfunction

  goit_pkg::state_t  state_r, state_nxt;
  logic [CLR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [goit_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [goit_pkg::ID_W-1:0]    id_r, id_nxt;
  logic [goit_pkg::COORD_W-1:0] x_r, x_nxt;
  logic [goit_pkg::COORD_W-1:0] y_r, y_nxt;
  logic [CIDX_W-1:0]            cidx_r, cidx_nxt;
  logic [goit_pkg::ENTRY_W-1:0] nid_r, nid_nxt;
  goit_pkg::result_t            res_r, res_nxt;
  logic                         out_valid_r, out_valid_nxt;
  goit_pkg::result_t            out_res_r, out_res_nxt;

  logic [6:0]  eff_w, eff_h;
  logic [13:0] area;
  logic [8:0]  limit;
  logic        inb;
  logic        occ_v, plc_v;
  logic        old_inb;
  logic [CIDX_W-1:0] old_cidx;

  always_comb begin
    eff_w   = ({2'b0, cfg.board_width} < MAXC_L) ? {2'b0, cfg.board_width} : MAXC_L;
    eff_h   = ({2'b0, cfg.board_height} < MAXR_L) ? {2'b0, cfg.board_height} : MAXR_L;
    area    = 14'(eff_w) * 14'(eff_h);
    limit   = (area > 14'd256) ? 9'd256 : area[8:0];
    inb     = ({3'b0, x_r} < eff_w) && ({3'b0, y_r} < eff_h);
    occ_v   = cell_rdata[8];
    plc_v   = piece_rdata[8];
    old_inb = ({3'b0, piece_rdata[7:4]} < MAXC_L) && ({3'b0, piece_rdata[3:0]} < MAXR_L);
    old_cidx = cell_index(piece_rdata[7:4], piece_rdata[3:0]);
  end

  assign cell_raddr  = cell_index(in_cell_x, in_cell_y);
  assign piece_raddr = in_piece_id;
  assign in_ready    = (state_r == goit_pkg::S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_res     = out_res_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    cidx_nxt      = cidx_r;
    nid_nxt       = nid_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cell_we       = 1'b0;
    cell_waddr    = cidx_r;
    cell_wdata    = '0;
    piece_we      = 1'b0;
    piece_waddr   = id_r;
    piece_wdata   = '0;
    unique case (state_r)
      goit_pkg::S_CLEAR: begin
        cell_we     = ({1'b0, clr_cnt_r} < (CLR_W+1)'(NUM_CELLS));
        cell_waddr  = clr_cnt_r[CIDX_W-1:0];
        piece_we    = ({1'b0, clr_cnt_r} < (CLR_W+1)'(goit_pkg::PIECES));
        piece_waddr = clr_cnt_r[goit_pkg::ID_W-1:0];
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_W'(CLR_DEPTH - 1)) begin
          state_nxt = goit_pkg::S_IDLE;
        end
      end
      goit_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          id_nxt    = in_piece_id;
          x_nxt     = in_cell_x;
          y_nxt     = in_cell_y;
          cidx_nxt  = cell_raddr;
          state_nxt = goit_pkg::S_EVAL;
        end
      end
      goit_pkg::S_EVAL: begin
        res_nxt   = '0;
        state_nxt = goit_pkg::S_OUT;
        unique case (op_r)
          goit_pkg::OP_ADD: begin
            if (!inb) begin
              res_nxt.status = goit_pkg::ST_BOUNDS;
            end else if (occ_v) begin
              res_nxt.status = goit_pkg::ST_OCCUPIED;
            end else if (nid_r >= limit) begin
              res_nxt.status = goit_pkg::ST_EXHAUSTED;
            end else begin
              res_nxt.result_id = nid_r[7:0];
              res_nxt.id_valid  = 1'b1;
              cell_we     = 1'b1;
              cell_wdata  = {1'b1, nid_r[7:0]};
              piece_we    = 1'b1;
              piece_waddr = nid_r[7:0];
              piece_wdata = {1'b1, x_r, y_r};
              nid_nxt     = nid_r + 1'b1;
            end
          end
          goit_pkg::OP_MOVE: begin
            if (!inb) begin
              res_nxt.status = goit_pkg::ST_BOUNDS;
            end else if (!plc_v) begin
              res_nxt.status = goit_pkg::ST_NOPIECE;
            end else if (!(occ_v && (cell_rdata[7:0] == id_r))) begin
              if (occ_v) begin
                res_nxt.result_id = cell_rdata[7:0];
                res_nxt.id_valid  = 1'b1;
                piece_we    = 1'b1;
                piece_waddr = cell_rdata[7:0];
              end
              cell_we    = old_inb;
              cell_waddr = old_cidx;
              state_nxt  = goit_pkg::S_WR2;
            end
          end
          goit_pkg::OP_REMOVE: begin
            if (!plc_v) begin
              res_nxt.status = goit_pkg::ST_NOPIECE;
            end else begin
              cell_we    = old_inb;
              cell_waddr = old_cidx;
              piece_we   = 1'b1;
            end
          end
          goit_pkg::OP_PEEK: begin
            if (!inb) begin
              res_nxt.status = goit_pkg::ST_BOUNDS;
            end else if (occ_v) begin
              res_nxt.result_id = cell_rdata[7:0];
              res_nxt.id_valid  = 1'b1;
            end
          end
          goit_pkg::OP_FIND: begin
            if (!plc_v) begin
              res_nxt.status = goit_pkg::ST_NOPIECE;
            end else begin
              res_nxt.found_x = piece_rdata[7:4];
              res_nxt.found_y = piece_rdata[3:0];
            end
          end
          default: begin
            res_nxt = '0;
          end
        endcase
      end
      goit_pkg::S_WR2: begin
        cell_we     = 1'b1;
        cell_wdata  = {1'b1, id_r};
        piece_we    = 1'b1;
        piece_wdata = {1'b1, x_r, y_r};
        state_nxt   = goit_pkg::S_OUT;
      end
      goit_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = goit_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = goit_pkg::S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= goit_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      nid_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      nid_r       <= nid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    id_r      <= id_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    cidx_r    <= cidx_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  `GOIT_ASSERT_RST(a_reset_blocks_input, !rst_n |=> !in_ready, "input taken straight after reset")
  `GOIT_ASSERT(a_idle_no_write, (state_r == goit_pkg::S_IDLE) |-> !cell_we && !piece_we,
               "table write while idle")
  `GOIT_ASSERT(a_id_only_in_eval, (state_r != goit_pkg::S_EVAL) |=> $stable(nid_r),
               "id counter moved outside evaluation")
  `GOIT_ASSERT(a_id_bound, nid_r <= 9'd256, "id counter beyond table size")
  `GOIT_ASSERT(a_accept_to_eval, (in_valid && in_ready) |=> (state_r == goit_pkg::S_EVAL),
               "accepted request not evaluated")

endmodule

// ----- hw/rtl/grid_occupancy_id_table_core.sv -----
// ----------------------------------------------------------------------------
// Grid occupancy id table
// Two-way map between board cells and piece ids with add, move, remove,
// peek and find requests.
//
// The input channel (in_valid/in_ready) takes one request with opcode,
// piece id and target cell; the output channel (out_valid/out_ready) gives
// exactly one result per request, in order. Board size is set through the
// cfg_ write port; the user writes it only while the block is idle, and the
// block itself does not enforce this. A request is taken in the idle state,
// checked against the read-back table entries in the evaluate state and its
// result loaded into the output register in the output state; a move that
// relocates a piece passes through an extra write state in between, as the
// cell and piece tables each have a single write port and the mover needs
// up to two writes to each.
// After reset both tables are cleared one entry per cycle; in_ready stays
// low meanwhile. If the receiver stalls, the result waits in the output
// register. One further request is still taken and evaluated; its result
// then waits until the output register is free, and in_ready stays low
// until it is loaded.
// ----------------------------------------------------------------------------
module grid_occupancy_id_table_core #(
  parameter int MAX_COLS = 16,
  parameter int MAX_ROWS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [goit_pkg::REG_W-1:0]    cfg_index,
  input  logic [goit_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [goit_pkg::OP_W-1:0]     in_opcode,
  input  logic [goit_pkg::ID_W-1:0]     in_piece_id,
  input  logic [goit_pkg::COORD_W-1:0]  in_cell_x,
  input  logic [goit_pkg::COORD_W-1:0]  in_cell_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [goit_pkg::ST_W-1:0]     out_status,
  output logic [goit_pkg::ID_W-1:0]     out_result_id,
  output logic                          out_id_valid,
  output logic [goit_pkg::COORD_W-1:0]  out_found_x,
  output logic [goit_pkg::COORD_W-1:0]  out_found_y
);

  localparam int NUM_CELLS = MAX_COLS * MAX_ROWS;
  localparam int CIDX_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  goit_pkg::cfg_t    cfg_r, cfg_nxt;
  goit_pkg::result_t res;

  logic                         cell_we;
  logic [CIDX_W-1:0]            cell_waddr;
  logic [goit_pkg::ENTRY_W-1:0] cell_wdata;
  logic [CIDX_W-1:0]            cell_raddr;
  logic [goit_pkg::ENTRY_W-1:0] cell_rdata;
  logic                         piece_we;
  logic [goit_pkg::ID_W-1:0]    piece_waddr;
  logic [goit_pkg::ENTRY_W-1:0] piece_wdata;
  logic [goit_pkg::ID_W-1:0]    piece_raddr;
  logic [goit_pkg::ENTRY_W-1:0] piece_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        goit_pkg::REG_BOARD_WIDTH:  cfg_nxt.board_width  = cfg_wdata;
        goit_pkg::REG_BOARD_HEIGHT: cfg_nxt.board_height = cfg_wdata;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.board_width  <= goit_pkg::BOARD_RESET;
      cfg_r.board_height <= goit_pkg::BOARD_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  goit_ram #(
    .DEPTH (NUM_CELLS),
    .WIDTH (goit_pkg::ENTRY_W),
    .AW    (CIDX_W)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  goit_ram #(
    .DEPTH (goit_pkg::PIECES),
    .WIDTH (goit_pkg::ENTRY_W),
    .AW    (goit_pkg::ID_W)
  ) u_piece_ram (
    .clk   (clk),
    .we    (piece_we),
    .waddr (piece_waddr),
    .wdata (piece_wdata),
    .raddr (piece_raddr),
    .rdata (piece_rdata)
  );

  goit_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CIDX_W   (CIDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_piece_id (in_piece_id),
    .in_cell_x   (in_cell_x),
    .in_cell_y   (in_cell_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_res     (res),
    .cell_we     (cell_we),
    .cell_waddr  (cell_waddr),
    .cell_wdata  (cell_wdata),
    .cell_raddr  (cell_raddr),
    .cell_rdata  (cell_rdata),
    .piece_we    (piece_we),
    .piece_waddr (piece_waddr),
    .piece_wdata (piece_wdata),
    .piece_raddr (piece_raddr),
    .piece_rdata (piece_rdata)
  );

  assign out_status    = res.status;
  assign out_result_id = res.result_id;
  assign out_id_valid  = res.id_valid;
  assign out_found_x   = res.found_x;
  assign out_found_y   = res.found_y;

endmodule
